[rtl/jsched_pkg.sv]
// package: constants and types shared by the job scheduler files
`timescale 1ns / 1ps
`default_nettype none
package jsched_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int TIME_BITS   = 16;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = PTR_BITS + 1;
    localparam int ADDR_BITS   = 2;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_SJF  = 2'd1;
    localparam logic [1:0] MODE_STCF = 2'd2;
    localparam logic [1:0] MODE_RR   = 2'd3;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    localparam logic [ADDR_BITS-1:0] REG_POLICY_MODE = '0;

    typedef logic [ID_BITS-1:0]   id_t;
    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [PTR_BITS-1:0]  ptr_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    typedef struct packed {
        id_t   id;
        time_t left;
    } entry_t;
endpackage
`default_nettype wire

[rtl/jsched_if.sv]
// channel interfaces: job/tick input and slot result output
`timescale 1ns / 1ps
`default_nettype none
interface jsched_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [jsched_pkg::ID_BITS-1:0]   job_id;
    logic [jsched_pkg::TIME_BITS-1:0] duration;
    modport source (output valid, func, job_id, duration, input ready);
    modport sink   (input valid, func, job_id, duration, output ready);
endinterface

interface jsched_out_if;
    logic                           valid;
    logic                           ready;
    logic                           busy_res;
    logic [jsched_pkg::ID_BITS-1:0] running_id;
    logic [4:0]                     queue_count;
    logic                           arrival_lost;
    modport source (output valid, busy_res, running_id, queue_count, arrival_lost, input ready);
    modport sink   (input valid, busy_res, running_id, queue_count, arrival_lost, output ready);
endinterface
`default_nettype wire

[rtl/jsched_qmem.sv]
// ready queue storage: one write port, one read port with registered data
`timescale 1ns / 1ps
`default_nettype none
module jsched_qmem (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire jsched_pkg::ptr_t    waddr,
    input  wire jsched_pkg::entry_t  wdata,
    input  wire jsched_pkg::ptr_t    raddr,
    output jsched_pkg::entry_t       rdata
);
    jsched_pkg::entry_t mem [jsched_pkg::QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/job_scheduler_fifo_sjf_srtf_rr.sv]
// job scheduler top level: control sequencer, run slot and configuration port
// an arrival goes into a free run slot, is dropped when the queue is full, is appended, or
// in SJF/STCF mode is inserted in order by a scan and a shift; the queue memory's single
// read port is walked one entry at a time
// one item is in work at a time; a finished result waits in the output register
// reset (rst_n low, asynchronous) empties run slot and queue, clears the lost flag and mode
`timescale 1ns / 1ps
`default_nettype none
module job_scheduler_fifo_sjf_srtf_rr (
    input  wire logic  clk,
    input  wire logic  rst_n,
    jsched_in_if.sink    in_ch,
    jsched_out_if.source out_ch,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [jsched_pkg::ADDR_BITS-1:0]    paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_TK_RD   = 4'd1;
    localparam logic [3:0] S_TK_PRE  = 4'd2;
    localparam logic [3:0] S_TK_RD2  = 4'd3;
    localparam logic [3:0] S_TK_MAIN = 4'd4;
    localparam logic [3:0] S_RR_RD   = 4'd5;
    localparam logic [3:0] S_RR_MAIN = 4'd6;
    localparam logic [3:0] S_SC_RD   = 4'd7;
    localparam logic [3:0] S_SC_CMP  = 4'd8;
    localparam logic [3:0] S_SH_RD   = 4'd9;
    localparam logic [3:0] S_SH_WR   = 4'd10;
    localparam logic [3:0] S_INS_WR  = 4'd11;
    localparam logic [3:0] S_EMIT    = 4'd12;

    localparam logic [1:0] RET_IDLE = 2'd0;
    localparam logic [1:0] RET_TICK = 2'd1;
    localparam logic [1:0] RET_EMIT = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;
    logic [1:0] mode_reg, mode_next;
    logic       rv_reg, rv_next;
    jsched_pkg::id_t   rj_reg, rj_next;
    jsched_pkg::time_t rl_reg, rl_next;
    jsched_pkg::ptr_t  head_reg, head_next;
    jsched_pkg::cnt_t  cnt_reg, cnt_next;
    logic       lost_reg, lost_next;
    jsched_pkg::entry_t ins_reg, ins_next;
    jsched_pkg::ptr_t  pos_reg, pos_next;
    jsched_pkg::ptr_t  k_reg, k_next;
    logic       busy_reg, busy_next;
    jsched_pkg::id_t   shown_reg, shown_next;
    logic       ov_reg, ov_next;
    logic       ob_reg, ob_next;
    jsched_pkg::id_t   oid_reg, oid_next;
    logic [4:0] ocnt_reg, ocnt_next;
    logic       olost_reg, olost_next;

    jsched_pkg::ptr_t   rd_idx, wr_idx;
    logic               we;
    jsched_pkg::entry_t wdata, hd;
    jsched_pkg::cnt_t   cnt_pop;
    logic               take, v1, busy1;
    jsched_pkg::id_t    j1;
    jsched_pkg::time_t  l1;
    logic               cfg_wr;

    jsched_qmem u_qmem (
        .clk   (clk),
        .we    (we),
        .waddr (head_reg + wr_idx),
        .wdata (wdata),
        .raddr (head_reg + rd_idx),
        .rdata (hd)
    );

    assign pready = 1'b1;
    assign prdata = {30'd0, mode_reg};
    assign cfg_wr = psel && penable && pwrite && (paddr == jsched_pkg::REG_POLICY_MODE);

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = ov_reg;
    assign out_ch.busy_res     = ob_reg;
    assign out_ch.running_id   = oid_reg;
    assign out_ch.queue_count  = ocnt_reg;
    assign out_ch.arrival_lost = olost_reg;

    assign cnt_pop = cnt_reg - jsched_pkg::cnt_t'(1);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        mode_next  = cfg_wr ? pwdata[1:0] : mode_reg;
        rv_next    = rv_reg;
        rj_next    = rj_reg;
        rl_next    = rl_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        lost_next  = lost_reg;
        ins_next   = ins_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        busy_next  = busy_reg;
        shown_next = shown_reg;
        ov_next    = ov_reg && !out_ch.ready;
        ob_next    = ob_reg;
        oid_next   = oid_reg;
        ocnt_next  = ocnt_reg;
        olost_next = olost_reg;
        rd_idx     = '0;
        wr_idx     = pos_reg;
        we         = 1'b0;
        wdata      = ins_reg;
        take       = 1'b0;
        v1         = 1'b0;
        j1         = '0;
        l1         = '0;
        busy1      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.func == jsched_pkg::FUNC_TICK)
                    begin
                        state_next = S_TK_RD;
                    end
                    else if (!rv_reg)
                    begin
                        rv_next = 1'b1;
                        rj_next = in_ch.job_id;
                        rl_next = in_ch.duration;
                    end
                    else if (cnt_reg < jsched_pkg::cnt_t'(jsched_pkg::QUEUE_DEPTH))
                    begin
                        ins_next = '{id: in_ch.job_id, left: in_ch.duration};
                        ret_next = RET_IDLE;
                        if ((mode_reg == jsched_pkg::MODE_SJF ||
                             mode_reg == jsched_pkg::MODE_STCF) && cnt_reg != '0)
                        begin
                            pos_next   = '0;
                            state_next = S_SC_RD;
                        end
                        else
                        begin
                            pos_next   = cnt_reg[jsched_pkg::PTR_BITS-1:0];
                            state_next = S_INS_WR;
                        end
                    end
                    else
                    begin
                        lost_next = 1'b1;
                    end
                end
            end
            S_TK_RD:
            begin
                state_next = S_TK_PRE;
            end
            S_TK_PRE:
            begin
                if (mode_reg == jsched_pkg::MODE_STCF && rv_reg && cnt_reg != '0 &&
                    hd.left < rl_reg)
                begin
                    // preempt: head runs, old run job goes back in order
                    rj_next   = hd.id;
                    rl_next   = hd.left;
                    head_next = head_reg + jsched_pkg::ptr_t'(1);
                    cnt_next  = cnt_pop;
                    ins_next  = '{id: rj_reg, left: rl_reg};
                    ret_next  = RET_TICK;
                    pos_next  = '0;
                    state_next = (cnt_pop != '0) ? S_SC_RD : S_INS_WR;
                end
                else
                begin
                    state_next = S_TK_MAIN;
                end
            end
            S_TK_RD2:
            begin
                state_next = S_TK_MAIN;
            end
            S_TK_MAIN:
            begin
                take = !rv_reg || rl_reg == '0;
                v1   = rv_reg;
                j1   = rj_reg;
                l1   = rl_reg;
                if (take)
                begin
                    if (cnt_reg != '0)
                    begin
                        v1        = 1'b1;
                        j1        = hd.id;
                        l1        = hd.left;
                        head_next = head_reg + jsched_pkg::ptr_t'(1);
                        cnt_next  = cnt_pop;
                    end
                    else
                    begin
                        v1 = 1'b0;
                        j1 = '0;
                        l1 = '0;
                    end
                end
                busy1      = v1 && l1 != '0;
                busy_next  = busy1;
                shown_next = busy1 ? j1 : '0;
                rv_next    = v1;
                rj_next    = j1;
                rl_next    = busy1 ? l1 - jsched_pkg::time_t'(1) : l1;
                state_next = (mode_reg == jsched_pkg::MODE_RR && v1) ? S_RR_RD : S_EMIT;
            end
            S_RR_RD:
            begin
                state_next = S_RR_MAIN;
            end
            S_RR_MAIN:
            begin
                if (busy_reg && rl_reg != '0)
                begin
                    if (cnt_reg != '0)
                    begin
                        rj_next    = hd.id;
                        rl_next    = hd.left;
                        head_next  = head_reg + jsched_pkg::ptr_t'(1);
                        cnt_next   = cnt_pop;
                        ins_next   = '{id: rj_reg, left: rl_reg};
                        ret_next   = RET_EMIT;
                        pos_next   = cnt_pop[jsched_pkg::PTR_BITS-1:0];
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    if (cnt_reg != '0)
                    begin
                        rv_next   = 1'b1;
                        rj_next   = hd.id;
                        rl_next   = hd.left;
                        head_next = head_reg + jsched_pkg::ptr_t'(1);
                        cnt_next  = cnt_pop;
                    end
                    else
                    begin
                        rv_next = 1'b0;
                        rj_next = '0;
                        rl_next = '0;
                    end
                    state_next = S_EMIT;
                end
            end
            S_SC_RD:
            begin
                rd_idx     = pos_reg;
                state_next = S_SC_CMP;
            end
            S_SC_CMP:
            begin
                // first entry with strictly more time left marks the slot
                if (hd.left > ins_reg.left)
                begin
                    k_next     = cnt_pop[jsched_pkg::PTR_BITS-1:0];
                    state_next = S_SH_RD;
                end
                else
                begin
                    pos_next = pos_reg + jsched_pkg::ptr_t'(1);
                    if ({1'b0, pos_reg} + jsched_pkg::cnt_t'(1) == cnt_reg)
                    begin
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        state_next = S_SC_RD;
                    end
                end
            end
            S_SH_RD:
            begin
                rd_idx     = k_reg;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                we     = 1'b1;
                wr_idx = k_reg + jsched_pkg::ptr_t'(1);
                wdata  = hd;
                if (k_reg == pos_reg)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    k_next     = k_reg - jsched_pkg::ptr_t'(1);
                    state_next = S_SH_RD;
                end
            end
            S_INS_WR:
            begin
                we       = 1'b1;
                wr_idx   = pos_reg;
                wdata    = ins_reg;
                cnt_next = cnt_reg + jsched_pkg::cnt_t'(1);
                case (ret_reg)
                    RET_TICK: state_next = S_TK_RD2;
                    RET_EMIT: state_next = S_EMIT;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    ob_next    = busy_reg;
                    oid_next   = shown_reg;
                    ocnt_next  = cnt_reg;
                    olost_next = lost_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_IDLE;
            mode_reg  <= jsched_pkg::MODE_FIFO;
            rv_reg    <= 1'b0;
            rj_reg    <= '0;
            rl_reg    <= '0;
            head_reg  <= '0;
            cnt_reg   <= '0;
            lost_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            mode_reg  <= mode_next;
            rv_reg    <= rv_next;
            rj_reg    <= rj_next;
            rl_reg    <= rl_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            lost_reg  <= lost_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg   <= ins_next;
        pos_reg   <= pos_next;
        k_reg     <= k_next;
        busy_reg  <= busy_next;
        shown_reg <= shown_next;
        ob_reg    <= ob_next;
        oid_reg   <= oid_next;
        ocnt_reg  <= ocnt_next;
        olost_reg <= olost_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= jsched_pkg::cnt_t'(jsched_pkg::QUEUE_DEPTH))
        else $error("ready queue count beyond depth");

    a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !rv_reg) |-> cnt_reg == '0)
        else $error("jobs waiting while the run slot is empty");

    a_lost_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(lost_reg))
        else $error("lost flag cleared without reset");

    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && state_next == S_IDLE) |=> ov_reg)
        else $error("tick result not loaded");
`endif
endmodule
`default_nettype wire

[sim/tb.sv]
// testbench for the job scheduler: directed and random arrivals and ticks checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import jsched_pkg::*;

    // predicts slot reports from arrivals and ticks and holds the reports still owed
    class slot_scoreboard;
        logic [1:0] mode;
        logic       run_valid;
        id_t        run_job;
        int         run_left;
        id_t        q_id[$];
        int         q_left[$];
        logic       lost;
        logic [14:0] owed[$];
        int         mismatches;
        int         reports;

        function new();
            mode = MODE_FIFO;
            run_valid = 0;
            run_job = '0;
            run_left = 0;
            lost = 0;
            mismatches = 0;
            reports = 0;
        endfunction

        function void enqueue(id_t id, int left, bit ordered);
            int pos;
            pos = q_id.size();
            if (ordered)
            begin
                for (int i = 0; i < q_id.size(); i++)
                begin
                    if (q_left[i] > left)
                    begin
                        pos = i;
                        break;
                    end
                end
            end
            q_id.insert(pos, id);
            q_left.insert(pos, left);
        endfunction

        function void take_head();
            if (q_id.size() > 0)
            begin
                run_job = q_id.pop_front();
                run_left = q_left.pop_front();
                run_valid = 1;
            end
            else
            begin
                run_valid = 0;
                run_job = '0;
                run_left = 0;
            end
        endfunction

        function void note_input(logic func, id_t id, time_t dur);
            bit   busy;
            id_t  shown;
            id_t  hid;
            int   hleft;
            if (func == FUNC_ARRIVAL)
            begin
                if (!run_valid)
                begin
                    run_valid = 1;
                    run_job = id;
                    run_left = dur;
                end
                else if (q_id.size() < QUEUE_DEPTH)
                    enqueue(id, dur, mode == MODE_SJF || mode == MODE_STCF);
                else
                    lost = 1;
                return;
            end
            if (mode == MODE_STCF && run_valid && q_id.size() > 0 && q_left[0] < run_left)
            begin
                hid = q_id.pop_front();
                hleft = q_left.pop_front();
                enqueue(run_job, run_left, 1);
                run_job = hid;
                run_left = hleft;
            end
            if (!run_valid || run_left == 0)
                take_head();
            busy = run_valid && run_left > 0;
            shown = busy ? run_job : '0;
            if (busy)
                run_left--;
            if (mode == MODE_RR && run_valid)
            begin
                if (busy && run_left > 0)
                begin
                    if (q_id.size() > 0)
                    begin
                        hid = q_id.pop_front();
                        hleft = q_left.pop_front();
                        enqueue(run_job, run_left, 0);
                        run_job = hid;
                        run_left = hleft;
                    end
                end
                else
                    take_head();
            end
            owed.push_back({busy, shown, 5'(q_id.size()), lost});
        endfunction

        function void check_report(logic busy, id_t id, logic [4:0] cnt, logic lst);
            logic [14:0] want;
            reports++;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected slot report busy=%0d id=%0d count=%0d lost=%0d",
                             busy, id, cnt, lst);
                return;
            end
            want = owed.pop_front();
            if (want !== {busy, id, cnt, lst})
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("slot report mismatch: exp busy=%0d id=%0d count=%0d lost=%0d",
                             want[14], want[13:6], want[5:1], want[0]);
                    $display("                      got busy=%0d id=%0d count=%0d lost=%0d",
                             busy, id, cnt, lst);
                end
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    jsched_in_if  in_ch();
    jsched_out_if out_ch();

    slot_scoreboard sched;
    int arrivals, ticks;
    bit modes_seen[4];

    always #5 clk = ~clk;

    job_scheduler_fifo_sjf_srtf_rr u_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic set_mode(logic [1:0] m);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_POLICY_MODE; pwdata <= 32'(m);
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        sched.mode = m;
        modes_seen[m] = 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // driven at the falling edge with blocking writes so back-to-back calls stay clean
    task automatic send(logic func, id_t id, time_t dur);
        int g;
        g = gap_len();
        repeat (g) @(negedge clk);
        if (g > 0)
        begin
            in_ch.valid = 0;
            @(negedge clk);
        end
        in_ch.valid = 1;
        in_ch.func = func;
        in_ch.job_id = id;
        in_ch.duration = dur;
        do @(posedge clk); while (!in_ch.ready);
        sched.note_input(func, id, dur);
        if (func == FUNC_ARRIVAL)
            arrivals++;
        else
            ticks++;
        @(negedge clk);
        in_ch.valid = 0;
    endtask

    // wait for every owed report, then let a last arrival settle
    task automatic drain();
        while (sched.owed.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic random_phase(int n, logic [1:0] m);
        int p;
        drain();
        set_mode(m);
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(0, 99);
            if (p < 45)
                send(FUNC_ARRIVAL, id_t'($urandom),
                     ($urandom_range(0, 19) == 0) ? time_t'($urandom) :
                     time_t'($urandom_range(0, 6)));
            else
                send(FUNC_TICK, id_t'($urandom), time_t'($urandom));
        end
    endtask

    // receiver with random stalls
    initial
    begin
        out_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sched.check_report(out_ch.busy_res, out_ch.running_id,
                               out_ch.queue_count, out_ch.arrival_lost);

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        sched = new();
        in_ch.valid = 0;
        in_ch.func = FUNC_ARRIVAL;
        in_ch.job_id = '0;
        in_ch.duration = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, zero duration, full queue, preemption
        send(FUNC_TICK, '0, '0);
        send(FUNC_ARRIVAL, 8'hFF, 16'hFFFF);
        send(FUNC_ARRIVAL, 8'h00, 16'h0000);
        send(FUNC_ARRIVAL, 8'h5A, 16'h0001);
        send(FUNC_TICK, '1, '1);
        send(FUNC_TICK, '0, '0);
        drain();
        set_mode(MODE_STCF);
        for (int i = 0; i < 18; i++)
            send(FUNC_ARRIVAL, id_t'(i + 1), time_t'(18 - i));
        send(FUNC_TICK, '0, '0);
        send(FUNC_TICK, '0, '0);

        random_phase(150, MODE_SJF);
        random_phase(150, MODE_RR);
        random_phase(150, MODE_STCF);
        random_phase(150, MODE_FIFO);
        random_phase(60, 2'($urandom));

        drain();
        $display("run covered %0d arrivals and %0d ticks, %0d slot reports checked",
                 arrivals, ticks, sched.reports);
        $display("policy modes exercised: fifo=%0d sjf=%0d srtf=%0d rr=%0d",
                 modes_seen[0], modes_seen[1], modes_seen[2], modes_seen[3]);
        if (sched.mismatches == 0 && sched.owed.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
rtl/jsched_pkg.sv
rtl/jsched_if.sv
rtl/jsched_qmem.sv
rtl/job_scheduler_fifo_sjf_srtf_rr.sv
sim/tb.sv
